/* sv/rwc_pkg.sv */
// Shared types and constants for the raycast wall column setup block.
`default_nettype none
package rwc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int TEX_MAX   = 1024;
  localparam int LH_W      = 16;
  localparam int Q26_W     = 26;
  localparam int COL_W     = 10;
  localparam int SH_W      = 13;
  localparam int TX_W      = 11;
  localparam int OFF_W     = LH_W - 1;

  localparam logic [LH_W-1:0]  LH_MAX  = '1;
  localparam logic [Q26_W-1:0] Q26_MAX = '1;
  localparam logic [COL_W-1:0] COL_MAX = COL_W'(TEX_MAX - 1);

  typedef enum logic [1:0] {
    TEX_NORTH = 2'd0,
    TEX_SOUTH = 2'd1,
    TEX_WEST  = 2'd2,
    TEX_EAST  = 2'd3
  } tex_sel_t;

  typedef enum logic [1:0] {
    CFG_SCREEN_H = 2'd0,
    CFG_TEX_W    = 2'd1,
    CFG_TEX_H    = 2'd2,
    CFG_NONE     = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    tex_sel_t         sel;
    logic [COL_W-1:0] col;
  } tex_info_t;

  typedef struct packed {
    tex_info_t        tex;
    logic [LH_W-1:0]  lh;
    logic [SH_W-1:0]  ds;
    logic [SH_W-1:0]  de;
    logic [OFF_W-1:0] off;
  } row_info_t;

endpackage
`default_nettype wire

/* sv/rwc_tex_col.sv */
// Texture select and texture column pipeline (three stages).
`default_nettype none
module rwc_tex_col (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_v,
  input  wire logic [31:0]               wdist,
  input  wire logic                      side,
  input  wire logic signed [17:0]        dx,
  input  wire logic signed [17:0]        dy,
  input  wire logic [25:0]               px,
  input  wire logic [25:0]               py,
  input  wire logic [rwc_pkg::TX_W-1:0]  tw,
  output logic                           out_v,
  output logic [31:0]                    out_dist,
  output rwc_pkg::tex_info_t             out_tex
);

  logic                   v1_r, v2_r, v3_r;
  logic [31:0]            dist1_r, dist2_r, dist3_r;
  rwc_pkg::tex_sel_t      sel1_r, sel2_r;
  logic                   mir1_r, mir2_r;
  logic [15:0]            base1_r;
  logic [31:0]            prod1_r;
  logic [rwc_pkg::TX_W-1:0] colw2_r;
  rwc_pkg::tex_info_t     tex3_r;

  rwc_pkg::tex_sel_t      sel_nxt;
  logic                   mir_nxt;
  logic [17:0]            dir;
  logic [31:0]            prod_nxt;
  logic [31:0]            frac;
  logic [42:0]            fprod;
  logic [rwc_pkg::TX_W-1:0] cm;
  rwc_pkg::tex_info_t     tex_nxt;

  always_comb begin
    if (!side) begin
      sel_nxt = dx[17] ? rwc_pkg::TEX_NORTH : rwc_pkg::TEX_SOUTH;
      mir_nxt = !dx[17] && (dx != '0);
      dir     = dy;
    end else begin
      sel_nxt = dy[17] ? rwc_pkg::TEX_WEST : rwc_pkg::TEX_EAST;
      mir_nxt = dy[17];
      dir     = dx;
    end
    prod_nxt = 32'(wdist * {{14{dir[17]}}, dir});
  end

  assign frac  = {base1_r, 16'd0} + prod1_r;
  assign fprod = {11'd0, frac} * {32'd0, tw};

  always_comb begin
    cm = mir2_r ? (tw - colw2_r - 11'd1) : colw2_r;
    tex_nxt.sel = sel2_r;
    if (tw == '0) begin
      tex_nxt.col = '0;
    end else if (cm > {1'b0, rwc_pkg::COL_MAX}) begin
      tex_nxt.col = rwc_pkg::COL_MAX;
    end else begin
      tex_nxt.col = cm[rwc_pkg::COL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    dist1_r <= wdist;
    sel1_r  <= sel_nxt;
    mir1_r  <= mir_nxt;
    base1_r <= side ? px[15:0] : py[15:0];
    prod1_r <= prod_nxt;
    dist2_r <= dist1_r;
    sel2_r  <= sel1_r;
    mir2_r  <= mir1_r;
    colw2_r <= fprod[42:32];
    dist3_r <= dist2_r;
    tex3_r  <= tex_nxt;
  end

  assign out_v    = v3_r;
  assign out_dist = dist3_r;
  assign out_tex  = tex3_r;

endmodule
`default_nettype wire

/* sv/rwc_lh_div.sv */
// Slice height divider: one quotient bit per stage, sixteen stages.
`default_nettype none
module rwc_lh_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_v,
  input  wire logic [31:0]               wdist,
  input  wire logic [rwc_pkg::SH_W-1:0]  h,
  input  wire rwc_pkg::tex_info_t        in_tex,
  output logic                           out_v,
  output logic [rwc_pkg::LH_W-1:0]       out_lh,
  output rwc_pkg::tex_info_t             out_tex
);

  localparam int N = rwc_pkg::LH_W;

  logic               v_r   [N];
  logic               sat_r [N];
  logic [32:0]        r_r   [N];
  logic [31:0]        d_r   [N];
  logic [N-1:0]       q_r   [N];
  rwc_pkg::tex_info_t tex_r [N];

  logic [32:0]  r_nxt [N];
  logic [N-1:0] q_nxt [N];

  always_comb begin
    for (int k = 0; k < N; k++) begin
      logic [32:0] rin;
      logic [32:0] rs;
      logic [31:0] dd;
      logic [N-1:0] qin;
      rin = (k == 0) ? {20'd0, h} : r_r[(k == 0) ? 0 : k - 1];
      dd  = (k == 0) ? wdist : d_r[(k == 0) ? 0 : k - 1];
      qin = (k == 0) ? '0 : q_r[(k == 0) ? 0 : k - 1];
      rs  = {rin[31:0], 1'b0};
      if (rs >= {1'b0, dd}) begin
        r_nxt[k] = rs - {1'b0, dd};
        q_nxt[k] = {qin[N-2:0], 1'b1};
      end else begin
        r_nxt[k] = rs;
        q_nxt[k] = {qin[N-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < N; k++) v_r[k] <= 1'b0;
    end else begin
      v_r[0] <= in_v;
      for (int k = 1; k < N; k++) v_r[k] <= v_r[k-1];
    end
    sat_r[0] <= (wdist == '0) || ({19'd0, h} >= wdist);
    d_r[0]   <= wdist;
    tex_r[0] <= in_tex;
    for (int k = 1; k < N; k++) begin
      sat_r[k] <= sat_r[k-1];
      d_r[k]   <= d_r[k-1];
      tex_r[k] <= tex_r[k-1];
    end
    for (int k = 0; k < N; k++) begin
      r_r[k] <= r_nxt[k];
      q_r[k] <= q_nxt[k];
    end
  end

  assign out_v   = v_r[N-1];
  assign out_lh  = sat_r[N-1] ? rwc_pkg::LH_MAX : q_r[N-1];
  assign out_tex = tex_r[N-1];

endmodule
`default_nettype wire

/* sv/rwc_step_div.sv */
// Texture step divider: one quotient bit per stage, twenty-six stages.
`default_nettype none
module rwc_step_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_v,
  input  wire logic [rwc_pkg::TX_W-1:0]  th,
  input  wire rwc_pkg::row_info_t        in_row,
  output logic                           out_v,
  output logic [rwc_pkg::Q26_W-1:0]      out_stp,
  output rwc_pkg::row_info_t             out_row
);

  localparam int N = rwc_pkg::Q26_W;

  logic               v_r   [N];
  logic               sat_r [N];
  logic [16:0]        r_r   [N];
  logic [N-1:0]       q_r   [N];
  rwc_pkg::row_info_t row_r [N];

  logic [16:0]  r_nxt [N];
  logic [N-1:0] q_nxt [N];
  logic [N-1:0] nbit;

  // dividend is th shifted up by FRAC_BITS; bits below that are zero
  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_nb
      if (g >= rwc_pkg::FRAC_BITS && g - rwc_pkg::FRAC_BITS < rwc_pkg::TX_W - 1) begin : g_th
        assign nbit[g] = th[g - rwc_pkg::FRAC_BITS];
      end else begin : g_z
        assign nbit[g] = 1'b0;
      end
    end
  endgenerate

  always_comb begin
    for (int k = 0; k < N; k++) begin
      logic [16:0]  rin;
      logic [16:0]  rs;
      logic [15:0]  dd;
      logic [N-1:0] qin;
      rin = (k == 0) ? {16'd0, th[rwc_pkg::TX_W-1]} : r_r[(k == 0) ? 0 : k - 1];
      dd  = (k == 0) ? in_row.lh : row_r[(k == 0) ? 0 : k - 1].lh;
      qin = (k == 0) ? '0 : q_r[(k == 0) ? 0 : k - 1];
      rs  = {rin[15:0], nbit[N-1-k]};
      if (rs >= {1'b0, dd}) begin
        r_nxt[k] = rs - {1'b0, dd};
        q_nxt[k] = {qin[N-2:0], 1'b1};
      end else begin
        r_nxt[k] = rs;
        q_nxt[k] = {qin[N-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < N; k++) v_r[k] <= 1'b0;
    end else begin
      v_r[0] <= in_v;
      for (int k = 1; k < N; k++) v_r[k] <= v_r[k-1];
    end
    sat_r[0] <= (in_row.lh == '0) || ({15'd0, th} >= {in_row.lh, 10'd0});
    row_r[0] <= in_row;
    for (int k = 1; k < N; k++) begin
      sat_r[k] <= sat_r[k-1];
      row_r[k] <= row_r[k-1];
    end
    for (int k = 0; k < N; k++) begin
      r_r[k] <= r_nxt[k];
      q_r[k] <= q_nxt[k];
    end
  end

  assign out_v   = v_r[N-1];
  assign out_stp = sat_r[N-1] ? rwc_pkg::Q26_MAX : q_r[N-1];
  assign out_row = row_r[N-1];

endmodule
`default_nettype wire

/* sv/raycast_wall_column_setup.sv */
// Top level of the raycast wall column setup pipeline.
// Throughput: one item per cycle; busy is never raised.
// Most of the pipeline depth lies in the two bit-serial divider pipelines (16 + 26 stages).
// Reset (rst_n low, synchronous) clears all valid bits and restores the registers
// to screen height 480 and texture size 64 x 64; the receiver cannot stall.
`default_nettype none
module raycast_wall_column_setup (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [31:0]        in_wall_distance,
  input  wire logic               in_hit_side,
  input  wire logic signed [17:0] in_ray_dir_x,
  input  wire logic signed [17:0] in_ray_dir_y,
  input  wire logic [25:0]        in_player_x,
  input  wire logic [25:0]        in_player_y,
  output logic                    out_valid,
  output logic [15:0]             out_line_height,
  output logic [12:0]             out_draw_start,
  output logic [12:0]             out_draw_end,
  output logic [1:0]              out_texture_select,
  output logic [9:0]              out_texture_column,
  output logic [25:0]             out_texture_step,
  output logic [25:0]             out_texture_start,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [12:0]        cfg_data
);

  // configuration registers; the user must write them only while the pipe is empty (not enforced here)
  logic [rwc_pkg::SH_W-1:0] scr_h_r;
  logic [rwc_pkg::TX_W-1:0] tex_w_r;
  logic [rwc_pkg::TX_W-1:0] tex_h_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_h_r <= 13'd480;
      tex_w_r <= 11'd64;
      tex_h_r <= 11'd64;
    end else if (cfg_valid) begin
      case (rwc_pkg::cfg_idx_t'(cfg_index))
        rwc_pkg::CFG_SCREEN_H: scr_h_r <= cfg_data;
        rwc_pkg::CFG_TEX_W:    tex_w_r <= cfg_data[rwc_pkg::TX_W-1:0];
        rwc_pkg::CFG_TEX_H:    tex_h_r <= cfg_data[rwc_pkg::TX_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic               v0_r;
  logic [31:0]        dist0_r;
  logic               side0_r;
  logic signed [17:0] dx0_r, dy0_r;
  logic [25:0]        px0_r, py0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start && !busy;
    end
    dist0_r <= in_wall_distance;
    side0_r <= in_hit_side;
    dx0_r   <= in_ray_dir_x;
    dy0_r   <= in_ray_dir_y;
    px0_r   <= in_player_x;
    py0_r   <= in_player_y;
  end

  // texture select / column: three stages
  logic               tc_v;
  logic [31:0]        tc_dist;
  rwc_pkg::tex_info_t tc_tex;

  rwc_tex_col u_tex_col (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (v0_r),
    .wdist    (dist0_r),
    .side     (side0_r),
    .dx       (dx0_r),
    .dy       (dy0_r),
    .px       (px0_r),
    .py       (py0_r),
    .tw       (tex_w_r),
    .out_v    (tc_v),
    .out_dist (tc_dist),
    .out_tex  (tc_tex)
  );

  // slice height: sixteen stages
  logic                      lh_v;
  logic [rwc_pkg::LH_W-1:0]  lh;
  rwc_pkg::tex_info_t        lh_tex;

  rwc_lh_div u_lh_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_v    (tc_v),
    .wdist   (tc_dist),
    .h       (scr_h_r),
    .in_tex  (tc_tex),
    .out_v   (lh_v),
    .out_lh  (lh),
    .out_tex (lh_tex)
  );

  // row placement
  logic                       pl_v_r;
  rwc_pkg::row_info_t         pl_row_r;
  rwc_pkg::row_info_t         pl_nxt;
  logic [rwc_pkg::SH_W-2:0]   half_h;
  logic [rwc_pkg::OFF_W-1:0]  half_lh;
  logic [rwc_pkg::LH_W-1:0]   de_sum;

  always_comb begin
    half_h       = scr_h_r[rwc_pkg::SH_W-1:1];
    half_lh      = lh[rwc_pkg::LH_W-1:1];
    de_sum       = {1'b0, half_lh} + {4'd0, half_h};
    pl_nxt.tex   = lh_tex;
    pl_nxt.lh    = lh;
    if (half_lh > {3'd0, half_h}) begin
      // slice taller than the screen: start clamps at the top row
      pl_nxt.ds  = '0;
      pl_nxt.off = half_lh - {3'd0, half_h};
    end else begin
      pl_nxt.ds  = rwc_pkg::SH_W'({3'd0, half_h} - half_lh);
      pl_nxt.off = '0;
    end
    if (de_sum >= {3'd0, scr_h_r}) begin
      pl_nxt.de = scr_h_r;
    end else begin
      pl_nxt.de = de_sum[rwc_pkg::SH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pl_v_r <= 1'b0;
    end else begin
      pl_v_r <= lh_v;
    end
    pl_row_r <= pl_nxt;
  end

  // texture step: twenty-six stages
  logic                      sd_v;
  logic [rwc_pkg::Q26_W-1:0] stp;
  rwc_pkg::row_info_t        sd_row;

  rwc_step_div u_step_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_v    (pl_v_r),
    .th      (tex_h_r),
    .in_row  (pl_row_r),
    .out_v   (sd_v),
    .out_stp (stp),
    .out_row (sd_row)
  );

  // start texel: offset above the screen top times step
  logic                      mu_v_r;
  logic [40:0]               mu_prod_r;
  logic [rwc_pkg::Q26_W-1:0] mu_stp_r;
  rwc_pkg::row_info_t        mu_row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mu_v_r <= 1'b0;
    end else begin
      mu_v_r <= sd_v;
    end
    mu_prod_r <= {26'd0, sd_row.off} * {15'd0, stp};
    mu_stp_r  <= stp;
    mu_row_r  <= sd_row;
  end

  // output register
  logic        o_v_r;
  logic [15:0] o_lh_r;
  logic [12:0] o_ds_r, o_de_r;
  logic [1:0]  o_sel_r;
  logic [9:0]  o_col_r;
  logic [25:0] o_stp_r, o_start_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else begin
      o_v_r <= mu_v_r;
    end
    o_lh_r  <= mu_row_r.lh;
    o_ds_r  <= mu_row_r.ds;
    o_de_r  <= mu_row_r.de;
    o_sel_r <= mu_row_r.tex.sel;
    o_col_r <= mu_row_r.tex.col;
    o_stp_r <= mu_stp_r;
    o_start_r <= (mu_prod_r[40:rwc_pkg::Q26_W] != '0) ? rwc_pkg::Q26_MAX
                                                       : mu_prod_r[rwc_pkg::Q26_W-1:0];
  end

  assign out_valid          = o_v_r;
  assign out_line_height    = o_lh_r;
  assign out_draw_start     = o_ds_r;
  assign out_draw_end       = o_de_r;
  assign out_texture_select = o_sel_r;
  assign out_texture_column = o_col_r;
  assign out_texture_step   = o_stp_r;
  assign out_texture_start  = o_start_r;

endmodule
`default_nettype wire

/* bench/raycast_wall_column_checker.sv */
// Checker for the raycast wall column setup block: predicts each column and compares results.
module raycast_wall_column_checker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic               busy,
  input  wire logic [31:0]        in_wall_distance,
  input  wire logic               in_hit_side,
  input  wire logic signed [17:0] in_ray_dir_x,
  input  wire logic signed [17:0] in_ray_dir_y,
  input  wire logic [25:0]        in_player_x,
  input  wire logic [25:0]        in_player_y,
  input  wire logic               out_valid,
  input  wire logic [15:0]        out_line_height,
  input  wire logic [12:0]        out_draw_start,
  input  wire logic [12:0]        out_draw_end,
  input  wire logic [1:0]         out_texture_select,
  input  wire logic [9:0]         out_texture_column,
  input  wire logic [25:0]        out_texture_step,
  input  wire logic [25:0]        out_texture_start,
  input  wire logic               cfg_valid,
  input  wire logic               cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [12:0]        cfg_data,
  output int                      fail_count,
  output int                      columns_pending,
  output int                      columns_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [15:0]       lh;
    logic [12:0]       ds;
    logic [12:0]       de;
    rwc_pkg::tex_sel_t sel;
    logic [9:0]        col;
    logic [25:0]       stp;
    logic [25:0]       tstart;
  } column_t;

  logic [12:0] screen_h;
  logic [10:0] tex_w;
  logic [10:0] tex_h;
  column_t     column_q[$];

  function automatic column_t predict_column(
    logic [31:0] wdist, logic side, logic [17:0] dx, logic [17:0] dy,
    logic [25:0] px, logic [25:0] py);
    column_t     c;
    logic [63:0] lh, half_h, half_lh, ds, de, col, stp, st, off, base, dir, hit, frac;
    lh = (wdist == 0) ? 64'(rwc_pkg::LH_MAX)
                      : ({51'd0, screen_h} << rwc_pkg::FRAC_BITS) / wdist;
    if (lh > 64'(rwc_pkg::LH_MAX)) lh = 64'(rwc_pkg::LH_MAX);
    half_h  = screen_h / 2;
    half_lh = lh / 2;
    ds = (half_lh > half_h) ? 64'd0 : half_h - half_lh;
    de = half_lh + half_h;
    if (de >= screen_h) de = screen_h;
    if (!side) c.sel = dx[17] ? rwc_pkg::TEX_NORTH : rwc_pkg::TEX_SOUTH;
    else       c.sel = dy[17] ? rwc_pkg::TEX_WEST : rwc_pkg::TEX_EAST;
    // hit point carries 32 fraction bits; only the fraction matters
    base = side ? {38'd0, px} : {38'd0, py};
    dir  = side ? {{46{dx[17]}}, dx} : {{46{dy[17]}}, dy};
    hit  = (base << rwc_pkg::FRAC_BITS) + {32'd0, wdist} * dir;
    frac = {32'd0, hit[31:0]};
    if (tex_w == 0) col = 0;
    else begin
      col = (frac * tex_w) >> 32;
      if ((!side && !dx[17] && dx != 0) || (side && dy[17])) col = tex_w - col - 1;
      if (col > rwc_pkg::TEX_MAX - 1) col = rwc_pkg::TEX_MAX - 1;
    end
    if (lh == 0) stp = 64'(rwc_pkg::Q26_MAX);
    else stp = ({53'd0, tex_h} << rwc_pkg::FRAC_BITS) / lh;
    if (stp > 64'(rwc_pkg::Q26_MAX)) stp = 64'(rwc_pkg::Q26_MAX);
    off = ds + half_lh - half_h;
    st  = off * stp;
    if (st > 64'(rwc_pkg::Q26_MAX)) st = 64'(rwc_pkg::Q26_MAX);
    c.lh = lh[15:0]; c.ds = ds[12:0]; c.de = de[12:0];
    c.col = col[9:0]; c.stp = stp[25:0]; c.tstart = st[25:0];
    return c;
  endfunction

  task automatic report(string what);
    fail_count++;
    if (fail_count <= 10) $display("%0t: mismatch: %s", $realtime, what);
  endtask

  always @(posedge clk) begin
    column_t e;
    if (!rst_n) begin
      screen_h <= 13'd480;
      tex_w    <= 11'd64;
      tex_h    <= 11'd64;
      column_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rwc_pkg::CFG_SCREEN_H: screen_h <= cfg_data;
          rwc_pkg::CFG_TEX_W:    tex_w    <= cfg_data[10:0];
          rwc_pkg::CFG_TEX_H:    tex_h    <= cfg_data[10:0];
          default: ;
        endcase
      end
      if (out_valid) begin
        if (column_q.size() == 0) report("result with nothing expected");
        else begin
          e = column_q.pop_front();
          columns_checked++;
          if (out_line_height !== e.lh)
            report($sformatf("line_height exp %0d got %0d", e.lh, out_line_height));
          if (out_draw_start !== e.ds)
            report($sformatf("draw_start exp %0d got %0d", e.ds, out_draw_start));
          if (out_draw_end !== e.de)
            report($sformatf("draw_end exp %0d got %0d", e.de, out_draw_end));
          if (out_texture_select !== e.sel)
            report($sformatf("texture_select exp %0d got %0d", e.sel, out_texture_select));
          if (out_texture_column !== e.col)
            report($sformatf("texture_column exp %0d got %0d", e.col, out_texture_column));
          if (out_texture_step !== e.stp)
            report($sformatf("texture_step exp %h got %h", e.stp, out_texture_step));
          if (out_texture_start !== e.tstart)
            report($sformatf("texture_start exp %h got %h", e.tstart, out_texture_start));
        end
      end
      // config only changes while idle, so the current shadow is the right one
      if (start && !busy)
        column_q.push_back(predict_column(in_wall_distance, in_hit_side, in_ray_dir_x,
                                          in_ray_dir_y, in_player_x, in_player_y));
    end
    columns_pending = column_q.size();
  end

  initial begin
    fail_count      = 0;
    columns_checked = 0;
    columns_pending = 0;
  end

endmodule

/* bench/raycast_wall_column_setup_tb.sv */
// Top of the raycast wall column setup testbench: stimulus, config phases and verdict.
module raycast_wall_column_setup_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [31:0]        in_wall_distance;
  logic               in_hit_side;
  logic signed [17:0] in_ray_dir_x;
  logic signed [17:0] in_ray_dir_y;
  logic [25:0]        in_player_x;
  logic [25:0]        in_player_y;
  logic               out_valid;
  logic [15:0]        out_line_height;
  logic [12:0]        out_draw_start;
  logic [12:0]        out_draw_end;
  logic [1:0]         out_texture_select;
  logic [9:0]         out_texture_column;
  logic [25:0]        out_texture_step;
  logic [25:0]        out_texture_start;
  logic               cfg_valid;
  logic               cfg_ready;
  rwc_pkg::cfg_idx_t  cfg_index;
  logic [12:0]        cfg_data;
  int                 fail_count;
  int                 columns_pending;
  int                 columns_checked;

  int idle_pct;      // share in a hundred of cycles in which the sender holds off
  int items_sent;
  int settings_used;

  raycast_wall_column_setup DUT (.*);

  raycast_wall_column_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

  // Present one column; start stays high across back-to-back items.
  // busy only moves at rising edges, so its value at the falling edge
  // tells whether the next rising edge takes the item.
  task automatic send_column(logic [31:0] wdist, logic side, logic [17:0] dx,
                             logic [17:0] dy, logic [25:0] px, logic [25:0] py);
    logic taken;
    start            <= 1'b1;
    in_wall_distance <= wdist;
    in_hit_side      <= side;
    in_ray_dir_x     <= dx;
    in_ray_dir_y     <= dy;
    in_player_x      <= px;
    in_player_y      <= py;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
    items_sent++;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic write_reg(rwc_pkg::cfg_idx_t idx, logic [12:0] val);
    logic taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
  endtask

  // Drain the pipeline, then let the pipe settle before touching registers.
  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (columns_pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic load_setting(logic [12:0] sh, logic [12:0] tw, logic [12:0] th);
    drain();
    write_reg(rwc_pkg::CFG_SCREEN_H, sh);
    write_reg(rwc_pkg::CFG_TEX_W, tw);
    write_reg(rwc_pkg::CFG_TEX_H, th);
    write_reg(rwc_pkg::CFG_NONE, 13'($urandom));   // unused index, must be ignored
    settings_used++;
  endtask

  // Mostly plausible distances, with near-zero and far-out ones mixed in.
  function automatic logic [31:0] pick_distance();
    case ($urandom_range(5))
      0:       return $urandom_range(3) == 0 ? 32'd0 : 32'($urandom_range(1, 16'hFFFF));
      1:       return $urandom;
      2:       return 32'($urandom_range(32'h0100_0000, 32'hFFFF_FFFF));
      default: return 32'($urandom_range(32'h0000_4000, 32'h0020_0000));
    endcase
  endfunction

  task automatic random_columns(int n);
    repeat (n)
      send_column(pick_distance(), 1'($urandom), 18'($urandom), 18'($urandom),
                  26'($urandom), 26'($urandom));
  endtask

  initial begin
    rst_n            = 1'b0;
    start            = 1'b0;
    in_wall_distance = '0;
    in_hit_side      = 1'b0;
    in_ray_dir_x     = '0;
    in_ray_dir_y     = '0;
    in_player_x      = '0;
    in_player_y      = '0;
    cfg_valid        = 1'b0;
    cfg_index        = rwc_pkg::CFG_SCREEN_H;
    cfg_data         = '0;
    idle_pct         = 20;
    items_sent       = 0;
    settings_used    = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners at reset settings: zero and tiny distance saturate,
    // unit distance, farthest wall, every side and sign, player extremes
    send_column(32'd0, 1'b0, 18'h20000, 18'h1FFFF, 26'd0, 26'h3FFFFFF);
    send_column(32'd1, 1'b1, 18'h1FFFF, 18'h20000, 26'h3FFFFFF, 26'd0);
    send_column(32'h0001_0000, 1'b0, 18'h10000, 18'h08000, 26'h0012345, 26'h0023456);
    send_column(32'h0001_0000, 1'b0, 18'h00000, 18'h3C000, 26'h0040000, 26'h0048000);
    send_column(32'h0001_0000, 1'b1, 18'h30000, 18'h00000, 26'h0018000, 26'h0010000);
    send_column(32'h0002_8000, 1'b1, 18'h04000, 18'h3F000, 26'h0050000, 26'h0020000);
    send_column(32'hFFFF_FFFF, 1'b0, 18'h1FFFF, 18'h1FFFF, 26'h3FFFFFF, 26'h3FFFFFF);
    send_column(32'hFFFF_FFFF, 1'b1, 18'h20000, 18'h20000, 26'd0, 26'd0);
    send_column(32'h0000_8000, 1'b0, 18'h3FFFF, 18'h00001, 26'h0001000, 26'h0002000);
    send_column(32'h0100_0000, 1'b1, 18'h00001, 18'h3FFFF, 26'h2000000, 26'h1000000);

    // zero registers: empty screen, zero texture width, zero line height
    load_setting(13'd0, 13'd0, 13'd0);
    send_column(32'd0, 1'b0, 18'h10000, 18'h10000, 26'h0012345, 26'h0054321);
    send_column(32'h0001_0000, 1'b1, 18'h30000, 18'h30000, 26'h0012345, 26'h0054321);
    random_columns(20);

    // largest values the register fields hold, so clamps on column and step bite
    load_setting(13'h1FFF, 13'h7FF, 13'h7FF);
    send_column(32'd0, 1'b0, 18'h10000, 18'h10000, 26'h00FFFFF, 26'h00FFFFF);
    send_column(32'h0000_0100, 1'b1, 18'h30000, 18'h30000, 26'h00FFFFF, 26'h00FFFFF);
    send_column(32'h7FFF_FFFF, 1'b0, 18'h10000, 18'h0FFFF, 26'h00FFFFF, 26'h00FFFFF);
    random_columns(60);

    load_setting(13'd1, 13'd1, 13'd1);
    random_columns(60);

    idle_pct = 77;
    load_setting(13'd4096, 13'd1024, 13'd1024);
    random_columns(70);
    load_setting(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 1024)),
                 13'($urandom_range(1, 1024)));
    random_columns(70);

    idle_pct = 0;
    load_setting(13'd480, 13'd64, 13'd64);
    random_columns(80);
    load_setting(13'($urandom), 13'($urandom), 13'($urandom));
    random_columns(80);

    drain();
    $display("Ran %0d columns over %0d register settings plus reset values;",
             items_sent, settings_used);
    $display("%0d results checked, %0d mismatches.", columns_checked, fail_count);
    if (fail_count == 0 && columns_pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/rwc_pkg.sv
sv/rwc_tex_col.sv
sv/rwc_lh_div.sv
sv/rwc_step_div.sv
sv/raycast_wall_column_setup.sv
bench/raycast_wall_column_checker.sv
bench/raycast_wall_column_setup_tb.sv
